@@ hdl/masked_cosine_similarity_unit_macros.svh @@
// Assertion macros shared by the masked cosine similarity unit.
// Depends on nothing; included by the modules that check their own logic.
`ifndef MASKED_COSINE_SIMILARITY_UNIT_MACROS_SVH
`define MASKED_COSINE_SIMILARITY_UNIT_MACROS_SVH

// Same-cycle implication under reset.
`define MCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Next-cycle implication under reset.
`define MCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ hdl/mcs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the masked cosine similarity unit.
// Depends on nothing.
package mcs_pkg;

   localparam int SUM_BITS = 48;
   localparam int ONE_Q14  = 16384;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] dot;
      logic [SUM_BITS-1:0]        first_norm;
      logic [SUM_BITS-1:0]        second_norm;
   } sums_type;

endpackage

@@ hdl/mcs_front.sv @@
`timescale 1ns / 1ps
// Front part: takes element transfers and keeps the saturating sums.
// Depends on mcs_pkg; pushes finished sums into mcs_queue.
module mcs_front import mcs_pkg::*; #(
   parameter int VALUE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [15:0] req_first_value,
   input  logic signed [15:0] req_second_value,
   input  logic              req_use_feature,
   input  logic              req_last_element,
   input  logic              queue_full,
   output logic              push,
   output sums_type          push_data
);

   localparam int PB = 2 * VALUE_BITS;
   localparam int DW = SUM_BITS + 2;
   localparam logic signed [DW-1:0] DOT_HI = DW'(signed'({1'b0, {(SUM_BITS-1){1'b1}}}));
   localparam logic signed [DW-1:0] DOT_LO = -DOT_HI - DW'(1);
   localparam logic [SUM_BITS:0] NORM_HI = {1'b0, {SUM_BITS{1'b1}}};

   logic signed [SUM_BITS-1:0] dot_ff, dot_in;
   logic [SUM_BITS-1:0]        n1_ff, n1_in, n2_ff, n2_in;
   logic [31:0]                a_raw, b_raw;
   logic signed [VALUE_BITS-1:0] a_v, b_v;
   logic signed [PB-1:0]       ab, aa, bb;
   logic signed [DW-1:0]       dot_sum;
   logic [SUM_BITS:0]          n1_sum, n2_sum;
   logic                       accept;
   sums_type                   next_sums;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   assign a_raw = {16'b0, req_first_value};
   assign b_raw = {16'b0, req_second_value};
   assign a_v   = signed'(a_raw[VALUE_BITS-1:0]);
   assign b_v   = signed'(b_raw[VALUE_BITS-1:0]);
   assign ab    = PB'(a_v) * PB'(b_v);
   assign aa    = PB'(a_v) * PB'(a_v);
   assign bb    = PB'(b_v) * PB'(b_v);

   always_comb begin
      dot_sum = DW'(dot_ff) + DW'(ab);
      n1_sum  = {1'b0, n1_ff} + (SUM_BITS + 1)'($unsigned(aa));
      n2_sum  = {1'b0, n2_ff} + (SUM_BITS + 1)'($unsigned(bb));
      next_sums.dot         = dot_ff;
      next_sums.first_norm  = n1_ff;
      next_sums.second_norm = n2_ff;
      if (req_use_feature) begin
         if (dot_sum > DOT_HI) begin
            next_sums.dot = DOT_HI[SUM_BITS-1:0];
         end else if (dot_sum < DOT_LO) begin
            next_sums.dot = DOT_LO[SUM_BITS-1:0];
         end else begin
            next_sums.dot = dot_sum[SUM_BITS-1:0];
         end
         next_sums.first_norm  = (n1_sum > NORM_HI) ? NORM_HI[SUM_BITS-1:0]
                                                    : n1_sum[SUM_BITS-1:0];
         next_sums.second_norm = (n2_sum > NORM_HI) ? NORM_HI[SUM_BITS-1:0]
                                                    : n2_sum[SUM_BITS-1:0];
      end
      dot_in = dot_ff;
      n1_in  = n1_ff;
      n2_in  = n2_ff;
      if (accept) begin
         if (req_last_element) begin
            dot_in = '0;
            n1_in  = '0;
            n2_in  = '0;
         end else begin
            dot_in = next_sums.dot;
            n1_in  = next_sums.first_norm;
            n2_in  = next_sums.second_norm;
         end
      end
   end

   assign push      = accept && req_last_element;
   assign push_data = next_sums;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         n1_ff  <= '0;
         n2_ff  <= '0;
      end else begin
         dot_ff <= dot_in;
         n1_ff  <= n1_in;
         n2_ff  <= n2_in;
      end
   end

endmodule

@@ hdl/mcs_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue of finished sums between the front and back parts.
// Depends on mcs_pkg and the assertion macro header.
`include "masked_cosine_similarity_unit_macros.svh"
module mcs_queue import mcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  sums_type push_data,
   input  logic     pop,
   output sums_type head,
   output logic     empty,
   output logic     full
);

   sums_type   slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   `MCS_ASSERT_NOW(a_no_overflow, clock, reset, push, !full)
   `MCS_ASSERT_NOW(a_no_underflow, clock, reset, pop, !empty)
   `MCS_ASSERT_NOW(a_ptr_count, clock, reset, count_ff != 2'd1, wptr_ff == rptr_ff)

endmodule

@@ hdl/mcs_back.sv @@
`timescale 1ns / 1ps
// Back part: square of the dot and norm product by a 48x16 multiplier, one 16-bit
// digit at a time, then a bit-serial root-ratio search and the output register.
// Depends on mcs_pkg and the assertion macro header.
`include "masked_cosine_similarity_unit_macros.svh"
module mcs_back import mcs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  sums_type           head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_similarity,
   output logic               rsp_zero_norm
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_CAND = 3'd2;
   localparam logic [2:0] S_TEST = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;
   localparam int WW = 128;
   localparam int MW = 2 * SUM_BITS;
   localparam logic [3:0] TOP_BIT = 4'd14;

   logic [2:0]          state_ff, state_in;
   logic [SUM_BITS-1:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [SUM_BITS-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic [MW-1:0]       acc_ff, acc_in, acc_next;
   logic [1:0]          idx_ff, idx_in;
   logic                pass_ff, pass_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic [WW-1:0]       r_ff, r_in, n_ff, n_in, p_ff, p_in, t_ff, t_in, cand_ff, cand_in;
   logic [3:0]          k_ff, k_in;
   logic [14:0]         q_ff, q_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  sim_ff, sim_in;
   logic                zn_ff, zn_in;
   logic [15:0]         digit;
   logic [63:0]         prod;
   logic [SUM_BITS-1:0] mag;
   logic                out_free;

   assign digit    = mul_b_ff[{idx_ff, 4'b0} +: 16];
   assign prod     = 64'(mul_a_ff) * 64'(digit);
   assign acc_next = acc_ff + (MW'(prod) << {idx_ff, 4'b0});
   assign mag      = head.dot[SUM_BITS-1] ? (~head.dot + 1'b1) : head.dot;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == S_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      pass_in      = pass_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      r_in         = r_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      t_in         = t_ff;
      cand_in      = cand_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      sim_in       = sim_ff;
      zn_in        = zn_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               neg_in   = head.dot[SUM_BITS-1];
               zero_in  = (head.first_norm == '0) || (head.second_norm == '0);
               mul_a_in = mag;
               mul_b_in = mag;
               n1_in    = head.first_norm;
               n2_in    = head.second_norm;
               acc_in   = '0;
               idx_in   = 2'd0;
               pass_in  = 1'b0;
               q_in     = '0;
               state_in = ((head.first_norm == '0) || (head.second_norm == '0))
                          ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            acc_in = acc_next;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               acc_in = '0;
               if (!pass_ff) begin
                  r_in     = WW'(acc_next) << 28;
                  mul_a_in = n1_ff;
                  mul_b_in = n2_ff;
                  pass_in  = 1'b1;
               end else begin
                  n_in     = WW'(acc_next);
                  p_in     = '0;
                  t_in     = '0;
                  k_in     = TOP_BIT;
                  state_in = S_CAND;
               end
            end
         end
         S_CAND: begin
            cand_in  = p_ff + (t_ff << (k_ff + 4'd1)) + (n_ff << {k_ff, 1'b0});
            state_in = S_TEST;
         end
         S_TEST: begin
            if ((cand_ff <= r_ff) && !q_ff[14]) begin
               q_in = q_ff | (15'd1 << k_ff);
               p_in = cand_ff;
               t_in = t_ff + (n_ff << k_ff);
            end
            if (k_ff == 4'd0) begin
               state_in = S_DONE;
            end else begin
               k_in     = k_ff - 4'd1;
               state_in = S_CAND;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               zn_in        = zero_ff;
               sim_in       = zero_ff ? 16'sd0
                            : (neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff}));
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      mul_b_ff <= mul_b_in;
      n1_ff    <= n1_in;
      n2_ff    <= n2_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      pass_ff  <= pass_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      r_ff     <= r_in;
      n_ff     <= n_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      cand_ff  <= cand_in;
      k_ff     <= k_in;
      q_ff     <= q_in;
      sim_ff   <= sim_in;
      zn_ff    <= zn_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_similarity = sim_ff;
   assign rsp_zero_norm  = zn_ff;

   `MCS_ASSERT_NOW(a_q_bound, clock, reset, state_ff == S_DONE, q_ff <= 15'(ONE_Q14))
   `MCS_ASSERT_NOW(a_zero_out, clock, reset, rsp_valid_ff && zn_ff, sim_ff == 16'sd0)
   `MCS_ASSERT_NEXT(a_done_load, clock, reset, (state_ff == S_DONE) && out_free, rsp_valid_ff)

endmodule

@@ hdl/masked_cosine_similarity_unit.sv @@
`timescale 1ns / 1ps
// Masked cosine similarity: one element transfer per cycle into the front sums
// while the queue is not full. Back part handles each vector pair in a load step,
// 6 multiply steps, 30 search steps and an output step; a pair with either norm
// zero skips the multiply and search steps, and a result can wait on the queue or a stalled output.
// A two-entry queue lets the front run ahead by two vector pairs before stalling.
// Synchronous reset clears the sums, the queue and the output valid.
module masked_cosine_similarity_unit import mcs_pkg::*; #(
   parameter int VALUE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_first_value,
   input  logic signed [15:0] req_second_value,
   input  logic               req_use_feature,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_similarity,
   output logic               rsp_zero_norm
);

   logic     push, pop, q_empty, q_full;
   sums_type push_data, head;

   mcs_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_value  (req_first_value),
      .req_second_value (req_second_value),
      .req_use_feature  (req_use_feature),
      .req_last_element (req_last_element),
      .queue_full       (q_full),
      .push             (push),
      .push_data        (push_data)
   );

   mcs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   mcs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (q_empty),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_similarity (rsp_similarity),
      .rsp_zero_norm  (rsp_zero_norm)
   );

endmodule

@@ tb/masked_cosine_similarity_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for masked_cosine_similarity_unit: streams element pairs,
// predicts each similarity with an exact integer search, and compares results.
// Depends on mcs_pkg and the unit's RTL.
module masked_cosine_similarity_unit_tb;
   import mcs_pkg::*;

   typedef struct {
      logic signed [15:0] first_value;
      logic signed [15:0] second_value;
      logic               use_feature;
      logic               last_element;
      logic               hold;
   } element_type;

   typedef struct {
      logic signed [15:0] similarity;
      logic               zero_norm;
   } similarity_type;

   localparam longint DOT_CEIL  = 64'sh7FFF_FFFF_FFFF;
   localparam longint DOT_FLOOR = -64'sh8000_0000_0000;
   localparam logic [63:0] NORM_CEIL = 64'hFFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_first_value = '0;
   logic signed [15:0] req_second_value = '0;
   logic req_use_feature = 1'b0;
   logic req_last_element = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_similarity;
   logic rsp_zero_norm;

   element_type    pending_elements[$];
   similarity_type expected_similarities[$];
   element_type    driven;
   longint         dot_acc;
   logic [63:0]    first_norm_acc;
   logic [63:0]    second_norm_acc;
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             mismatches = 0;
   int             vectors_checked = 0;
   int             zero_norm_seen = 0;
   int             elements_sent = 0;

   masked_cosine_similarity_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_first_value(req_first_value), .req_second_value(req_second_value),
      .req_use_feature(req_use_feature), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_similarity(rsp_similarity), .rsp_zero_norm(rsp_zero_norm)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Largest q in [0, ONE_Q14] with q^2 * n1 * n2 <= d^2 * 2^28.
   function automatic int unsigned cosine_magnitude(logic [63:0] d, logic [63:0] n1,
                                                    logic [63:0] n2);
      logic [191:0] rhs, norms, lhs;
      int unsigned lo, hi, mid;
      rhs = d;
      rhs = (rhs * rhs) << 28;
      norms = n1;
      norms = norms * n2;
      lo = 0;
      hi = ONE_Q14;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = mid * mid;
         lhs = lhs * norms;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic accumulate_element(element_type e);
      longint a, b, s;
      logic [63:0] p;
      similarity_type r;
      logic [63:0] mag;
      int unsigned q;
      a = e.first_value;
      b = e.second_value;
      if (e.use_feature) begin
         s = dot_acc + a * b;
         dot_acc = s > DOT_CEIL ? DOT_CEIL : (s < DOT_FLOOR ? DOT_FLOOR : s);
         p = first_norm_acc + 64'(a * a);
         first_norm_acc = p > NORM_CEIL ? NORM_CEIL : p;
         p = second_norm_acc + 64'(b * b);
         second_norm_acc = p > NORM_CEIL ? NORM_CEIL : p;
      end
      if (e.last_element) begin
         if (first_norm_acc == 0 || second_norm_acc == 0) begin
            r.similarity = '0;
            r.zero_norm = 1'b1;
         end else begin
            mag = dot_acc < 0 ? 64'(-dot_acc) : 64'(dot_acc);
            q = cosine_magnitude(mag, first_norm_acc, second_norm_acc);
            r.similarity = dot_acc < 0 ? -16'(q) : 16'(q);
            r.zero_norm = 1'b0;
         end
         expected_similarities = {expected_similarities, r};
         dot_acc = 0;
         first_norm_acc = 0;
         second_norm_acc = 0;
      end
   endtask

   // Driver: advance to the next pending element when the current transfer completes.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) accumulate_element(driven);
         if (!req_valid || !req_stall) begin
            if (pending_elements.size() > 0
                && !(pending_elements[0].hold && expected_similarities.size() > 0)
                && $urandom_range(99) >= send_idle_pct) begin
               driven = pending_elements.pop_front();
               req_first_value <= driven.first_value;
               req_second_value <= driven.second_value;
               req_use_feature <= driven.use_feature;
               req_last_element <= driven.last_element;
               req_valid <= 1'b1;
               elements_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_similarities.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: similarity %0d zero_norm %0d",
                           rsp_similarity, rsp_zero_norm);
            end else begin
               if (rsp_similarity !== expected_similarities[0].similarity
                   || rsp_zero_norm !== expected_similarities[0].zero_norm) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d: expected %0d/%0d got %0d/%0d", vectors_checked,
                              expected_similarities[0].similarity,
                              expected_similarities[0].zero_norm,
                              rsp_similarity, rsp_zero_norm);
               end
               if (expected_similarities[0].zero_norm) zero_norm_seen++;
               void'(expected_similarities.pop_front());
               vectors_checked++;
            end
         end
      end
   end

   task automatic add_element(logic signed [15:0] a, logic signed [15:0] b, logic use_it,
                              logic last, logic hold = 1'b0);
      element_type e;
      e.first_value = a;
      e.second_value = b;
      e.use_feature = use_it;
      e.last_element = last;
      e.hold = hold;
      pending_elements = {pending_elements, e};
   endtask

   function automatic logic signed [15:0] random_value();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
         2: return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom_range(4095));
      endcase
   endfunction

   task automatic add_random_vectors(int element_count);
      int n, len, i, kind, mask_pct;
      logic signed [15:0] a, b;
      n = 0;
      while (n < element_count) begin
         len = $urandom_range(9) == 0 ? $urandom_range(40, 13) : $urandom_range(12, 1);
         kind = $urandom_range(4);
         mask_pct = $urandom_range(7) == 0 ? 0 : $urandom_range(100, 40);
         for (i = 0; i < len; i++) begin
            a = random_value();
            case (kind)
               0: b = a;
               1: b = -a;
               2: b = a + 16'($signed($urandom_range(16)) - 8);
               default: b = random_value();
            endcase
            add_element(a, b, $urandom_range(99) < mask_pct, i == len - 1);
         end
         n += len;
      end
   endtask

   task automatic wait_for_drain();
      while (pending_elements.size() > 0 || req_valid || expected_similarities.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      dot_acc = 0;
      first_norm_acc = 0;
      second_norm_acc = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      add_element(16'sh7FFF, 16'sh7FFF, 1, 1);
      add_element(-16'sh8000, -16'sh8000, 1, 1);
      add_element(-16'sh8000, 16'sh7FFF, 1, 1);
      add_element(16'sh1000, 16'sh1000, 0, 1);
      add_element(16'sh0000, 16'sh1234, 1, 1);
      add_element(16'sh1234, 16'sh0000, 1, 1);
      add_element(16'sh1000, 16'sh0000, 1, 0);
      add_element(16'sh0000, 16'sh1000, 1, 1);
      add_element(16'sh0003, 16'sh0004, 1, 0);
      add_element(16'sh0004, -16'sh0003, 1, 0);
      add_element(16'sh5555, 16'shAAAA, 0, 1);
      add_element(16'sh0001, 16'sh0001, 1, 0);
      add_element(-16'sh0001, 16'sh0001, 1, 1);
      add_element(16'sh0001, -16'sh8000, 1, 0);
      add_element(16'sh7FFF, 16'sh0001, 1, 1);
      add_element(16'shFFFF, 16'sh5A5A, 1, 1);

      send_idle_pct = 28;
      recv_idle_pct = 80;
      add_random_vectors(380);
      add_element(16'sh0700, 16'sh0900, 1, 1, 1'b1);
      add_random_vectors(20);
      wait_for_drain();

      send_idle_pct = 80;
      recv_idle_pct = 28;
      add_random_vectors(380);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_vectors(360);
      add_random_vectors(20);
      wait_for_drain();
      repeat (100) @(posedge clock);

      $display("sent %0d elements, checked %0d similarities (%0d with zero norm)",
               elements_sent, vectors_checked, zero_norm_seen);
      $display("covered extremes, masked and unmasked lasts, a drain pause, three stall mixes");
      if (mismatches == 0 && expected_similarities.size() == 0) begin
         $display("masked_cosine_similarity_unit: match");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("masked_cosine_similarity_unit: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout");
      $display("masked_cosine_similarity_unit: mismatch");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mcs_pkg.sv
hdl/mcs_front.sv
hdl/mcs_queue.sv
hdl/mcs_back.sv
hdl/masked_cosine_similarity_unit.sv
tb/masked_cosine_similarity_unit_tb.sv
